// ===== rtl/decimal_price_to_fixed_point_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal price converter
// Shared check forms so that every assertion reads the same way.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_PRICE_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_PRICE_TO_FIXED_POINT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decimal price converter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decimal price converter: next-cycle check failed");

`endif

// ===== rtl/dpfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal price converter package
// Result status codes, digit error codes and the scaling tables.
// ----------------------------------------------------------------------------
package dpfp_pkg;

   localparam int UNITS_W  = 63;
   localparam int PLACES_W = 5;
   localparam int POW_W    = 60;

   localparam logic [PLACES_W-1:0] MAX_PLACES = 5'd18;
   localparam logic [PLACES_W-1:0] FRAC_SAT   = 5'd19;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   // Result status returned with every finished price.
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EMPTY       = 3'd1,
      ST_MULTI_POINT = 3'd2,
      ST_PRECISION   = 3'd3,
      ST_NON_DIGIT   = 3'd4,
      ST_OVERFLOW    = 3'd5,
      ST_ZERO        = 3'd6
   } status_type;

   // First error seen while accumulating digits.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NON_DIGIT = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } digit_err_type;

   // Powers of ten used to pad missing fraction digits.
   function automatic logic [POW_W-1:0] pow_ten(input logic [PLACES_W-1:0] k);
      logic [POW_W-1:0] p;
      case (k)
         5'd0:    p = 60'd1;
         5'd1:    p = 60'd10;
         5'd2:    p = 60'd100;
         5'd3:    p = 60'd1000;
         5'd4:    p = 60'd10000;
         5'd5:    p = 60'd100000;
         5'd6:    p = 60'd1000000;
         5'd7:    p = 60'd10000000;
         5'd8:    p = 60'd100000000;
         5'd9:    p = 60'd1000000000;
         5'd10:   p = 60'd10000000000;
         5'd11:   p = 60'd100000000000;
         5'd12:   p = 60'd1000000000000;
         5'd13:   p = 60'd10000000000000;
         5'd14:   p = 60'd100000000000000;
         5'd15:   p = 60'd1000000000000000;
         5'd16:   p = 60'd10000000000000000;
         5'd17:   p = 60'd100000000000000000;
         5'd18:   p = 60'd1000000000000000000;
         default: p = 60'd1;
      endcase
      return p;
   endfunction

   // Largest value that can be scaled by ten to the k without overflow.
   function automatic logic [UNITS_W-1:0] pad_limit(input logic [PLACES_W-1:0] k);
      logic [UNITS_W-1:0] t;
      case (k)
         5'd0:    t = 63'd9223372036854775807;
         5'd1:    t = 63'd922337203685477580;
         5'd2:    t = 63'd92233720368547758;
         5'd3:    t = 63'd9223372036854775;
         5'd4:    t = 63'd922337203685477;
         5'd5:    t = 63'd92233720368547;
         5'd6:    t = 63'd9223372036854;
         5'd7:    t = 63'd922337203685;
         5'd8:    t = 63'd92233720368;
         5'd9:    t = 63'd9223372036;
         5'd10:   t = 63'd922337203;
         5'd11:   t = 63'd92233720;
         5'd12:   t = 63'd9223372;
         5'd13:   t = 63'd922337;
         5'd14:   t = 63'd92233;
         5'd15:   t = 63'd9223;
         5'd16:   t = 63'd922;
         5'd17:   t = 63'd92;
         5'd18:   t = 63'd9;
         default: t = 63'd9223372036854775807;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/decimal_price_to_fixed_point.sv =====
// ----------------------------------------------------------------------------
// Decimal price to fixed-point converter
// Parses an ASCII decimal price one character per request and returns the
// price scaled by ten to the configured number of decimal places.
// ----------------------------------------------------------------------------
// The block takes one character of price text per cycle, back to back, while
// req_stall is low, and keeps a running digit total with a signed 64-bit
// overflow check on every digit. The request marked last closes the text: its
// result (units and status) appears on the response channel after the
// pipeline registers for the text snapshot, the lookup of the padding power of
// ten and limit, the three partial products of 32-bit operand slices with the
// limit check, and the final sum. The next text may start in the cycle right
// after a last character. The decimal_places register is written through
// csr_wr_en and csr_wr_data and is read when the last character of a text is
// taken; values above 18 give the empty status.
`include "decimal_price_to_fixed_point_macros.svh"

module decimal_price_to_fixed_point (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration
   input  logic                                 csr_wr_en,
   input  logic [dpfp_pkg::PLACES_W-1:0]        csr_wr_data,
   // Character requests
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_character,
   input  logic                                 req_has_char,
   input  logic                                 req_last,
   // Results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dpfp_pkg::UNITS_W-1:0]         rsp_units,
   output dpfp_pkg::status_type                 rsp_status
);

   import dpfp_pkg::*;

   // Configuration register.
   logic [PLACES_W-1:0] places_ff;

   // Text state.
   logic [UNITS_W-1:0]  acc_ff, acc_in;
   logic [PLACES_W-1:0] frac_ff, frac_in;
   logic                point_ff, point_in;
   logic                second_ff, second_in;
   logic                whole_ff, whole_in;
   logic                any_ff, any_in;
   digit_err_type       err_ff, err_in;

   // Character decode.
   logic                req_accept;
   logic                is_point;
   logic                is_other;
   logic                is_digit;
   logic [3:0]          digit;
   logic [UNITS_W+3:0]  acc_wide;

   // Pipeline stage one: snapshot of a finished text.
   logic                p1_valid_ff;
   logic [UNITS_W-1:0]  p1_units_ff;
   logic [PLACES_W-1:0] p1_pad_ff, p1_pad_in;
   status_type          p1_status_ff, p1_status_in;

   // Pipeline stage two: table lookups.
   logic                p2_valid_ff;
   logic [UNITS_W-1:0]  p2_units_ff;
   logic [POW_W-1:0]    p2_pow_ff;
   logic [UNITS_W-1:0]  p2_limit_ff;
   status_type          p2_status_ff;

   // Pipeline stage three: partial products and flags.
   logic                p3_valid_ff;
   logic [63:0]         p3_ll_ff;
   logic [30:0]         p3_lh_ff;
   logic [30:0]         p3_hl_ff;
   logic                p3_ovf_ff;
   logic                p3_zero_ff;
   status_type          p3_status_ff;
   logic [63:0]         pp_ll;
   logic [59:0]         pp_lh;
   logic [62:0]         pp_hl;

   // Output stage.
   logic                rsp_valid_ff;
   logic [UNITS_W-1:0]  rsp_units_ff, rsp_units_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [30:0]         cross_sum;
   logic [UNITS_W-1:0]  scaled;

   // Stage ready chain: a stage moves when it is empty or its successor moves.
   logic rdy4, rdy3, rdy2, rdy1;

   assign rdy4 = !rsp_valid_ff || !rsp_stall;
   assign rdy3 = !p3_valid_ff || rdy4;
   assign rdy2 = !p2_valid_ff || rdy3;
   assign rdy1 = !p1_valid_ff || rdy2;

   assign req_stall  = !rdy1;
   assign req_accept = req_valid && rdy1;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         places_ff <= '0;
      end else if (csr_wr_en) begin
         places_ff <= csr_wr_data;
      end
   end

   // Character decode and running digit total.
   always_comb begin
      is_point = req_has_char && (req_character == CHAR_POINT);
      is_other = req_has_char && (req_character != CHAR_POINT);
      is_digit = req_character inside {[CHAR_ZERO:CHAR_NINE]};
      digit    = 4'(req_character - CHAR_ZERO);
      // Ten times the total plus the digit, wide enough to show overflow.
      acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {63'b0, digit};

      acc_in    = acc_ff;
      frac_in   = frac_ff;
      point_in  = point_ff || is_point;
      second_in = second_ff || (is_point && point_ff);
      whole_in  = whole_ff || (is_other && !point_ff);
      any_in    = any_ff || req_has_char;
      err_in    = err_ff;

      if (is_other && point_ff && (frac_ff < FRAC_SAT)) begin
         frac_in = frac_ff + 5'd1;
      end
      if (is_other && (err_ff == ERR_NONE)) begin
         if (!is_digit) begin
            err_in = ERR_NON_DIGIT;
         end else if (acc_wide[UNITS_W+3:UNITS_W] != 4'b0) begin
            err_in = ERR_OVERFLOW;
         end else begin
            acc_in = acc_wide[UNITS_W-1:0];
         end
      end
   end

   // Early status of a finished text, in priority order.
   always_comb begin
      p1_pad_in = places_ff - frac_in;
      if (!any_in || (places_ff > MAX_PLACES)) begin
         p1_status_in = ST_EMPTY;
      end else if (second_in) begin
         p1_status_in = ST_MULTI_POINT;
      end else if (!whole_in || (frac_in > places_ff)) begin
         p1_status_in = ST_PRECISION;
      end else if (err_in == ERR_NON_DIGIT) begin
         p1_status_in = ST_NON_DIGIT;
      end else if (err_in == ERR_OVERFLOW) begin
         p1_status_in = ST_OVERFLOW;
      end else begin
         p1_status_in = ST_OK;
      end
   end

   // Text state: cleared after every last character.
   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_last)) begin
         acc_ff    <= '0;
         frac_ff   <= '0;
         point_ff  <= 1'b0;
         second_ff <= 1'b0;
         whole_ff  <= 1'b0;
         any_ff    <= 1'b0;
         err_ff    <= ERR_NONE;
      end else if (req_accept) begin
         acc_ff    <= acc_in;
         frac_ff   <= frac_in;
         point_ff  <= point_in;
         second_ff <= second_in;
         whole_ff  <= whole_in;
         any_ff    <= any_in;
         err_ff    <= err_in;
      end
   end

   // Partial products of the padding multiply; the top product falls off.
   always_comb begin
      pp_ll = p2_units_ff[31:0] * p2_pow_ff[31:0];
      pp_lh = p2_units_ff[31:0] * p2_pow_ff[59:32];
      pp_hl = p2_units_ff[62:32] * p2_pow_ff[31:0];
   end

   // Final sum and result status.
   always_comb begin
      cross_sum = p3_lh_ff + p3_hl_ff;
      scaled    = p3_ll_ff[UNITS_W-1:0] + {cross_sum, 32'b0};
      rsp_units_in  = '0;
      rsp_status_in = p3_status_ff;
      if (p3_status_ff == ST_OK) begin
         if (p3_ovf_ff) begin
            rsp_status_in = ST_OVERFLOW;
         end else if (p3_zero_ff) begin
            rsp_status_in = ST_ZERO;
         end else begin
            rsp_units_in = scaled;
         end
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            p1_valid_ff <= req_accept && req_last;
         end
         if (rdy2) begin
            p2_valid_ff <= p1_valid_ff;
         end
         if (rdy3) begin
            p3_valid_ff <= p2_valid_ff;
         end
         if (rdy4) begin
            rsp_valid_ff <= p3_valid_ff;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_units_ff  <= acc_in;
         p1_pad_ff    <= p1_pad_in;
         p1_status_ff <= p1_status_in;
      end
      if (rdy2) begin
         p2_units_ff  <= p1_units_ff;
         p2_pow_ff    <= pow_ten(p1_pad_ff);
         p2_limit_ff  <= pad_limit(p1_pad_ff);
         p2_status_ff <= p1_status_ff;
      end
      if (rdy3) begin
         p3_ll_ff     <= pp_ll;
         p3_lh_ff     <= pp_lh[30:0];
         p3_hl_ff     <= pp_hl[30:0];
         p3_ovf_ff    <= p2_units_ff > p2_limit_ff;
         p3_zero_ff   <= p2_units_ff == '0;
         p3_status_ff <= p2_status_ff;
      end
      if (rdy4) begin
         rsp_units_ff  <= rsp_units_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_units  = rsp_units_ff;
   assign rsp_status = rsp_status_ff;

   // Checks.
   `DPF_ASSERT_SAME(a_err_units_zero, clock, reset,
      rsp_valid && (rsp_status != ST_OK), rsp_units == '0)
   `DPF_ASSERT_NEXT(a_last_enters_pipe, clock, reset,
      req_valid && !req_stall && req_last, p1_valid_ff)
   `DPF_ASSERT_NEXT(a_text_cleared, clock, reset,
      req_valid && !req_stall && req_last, !any_ff && (acc_ff == '0) && (frac_ff == '0))
   `DPF_ASSERT_SAME(a_frac_saturates, clock, reset, 1'b1, frac_ff <= FRAC_SAT)
   `DPF_ASSERT_NEXT(a_bad_places_empty, clock, reset,
      req_valid && !req_stall && req_last && (places_ff > MAX_PLACES),
      p1_status_ff == ST_EMPTY)

endmodule
